>>> sv/rep_pkg.sv
`timescale 1ns / 1ps

package rep_pkg;

   // Item command codes
   localparam logic [1:0] CMD_FRAME   = 2'd0;
   localparam logic [1:0] CMD_TIME    = 2'd1;
   localparam logic [1:0] CMD_REQUEST = 2'd2;

   // Motor action codes
   localparam logic [1:0] ACT_NONE  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_STOP  = 2'd2;

   localparam int LVL_W  = 20;
   localparam int DUR_W  = 25;
   localparam int FC_W   = 32;
   localparam int PROD_W = 47;
   localparam int NUM_W  = 48;
   localparam int REM_W  = 29;
   localparam int Q_W    = 4;

   // One second / full level on the 2^19 scale, and 0.1 s rounded down
   localparam logic [LVL_W:0]   FULL_SCALE     = 21'd524288;
   localparam logic [DUR_W-1:0] NEAR_END_LIMIT = 25'd52428;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIFF,
      ST_CHECK,
      ST_DIVIDE,
      ST_PERIOD,
      ST_MODULO,
      ST_MODEND,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic       latch;
      logic       exec;
      logic       diff;
      logic       div_step;
      logic       mod_init;
      logic       mod_step;
      logic       commit;
      logic       on_value;
      logic [4:0] bit_idx;
   } rep_cmd_type;

   typedef struct packed {
      logic is_frame;
      logic rumble;
      logic env_done;
      logic num_pos;
      logic q_zero;
      logic mod_zero;
   } rep_stat_type;

endpackage

>>> sv/rep_ctrl.sv
`timescale 1ns / 1ps

module rep_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_accept,
   input  logic                  out_free,
   input  rep_pkg::rep_stat_type stat,
   output logic                  busy,
   output rep_pkg::rep_cmd_type  cmd
);

   rep_pkg::ctrl_state_type state_ff, state_in;
   logic [4:0]              cnt_ff, cnt_in;
   logic                    new_on_ff, new_on_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rep_pkg::ST_IDLE;
         cnt_ff    <= '0;
         new_on_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         new_on_ff <= new_on_in;
      end
   end

   // Next state
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      new_on_in = new_on_ff;
      case (state_ff)
         rep_pkg::ST_IDLE: begin
            if (req_accept) state_in = rep_pkg::ST_EXEC;
         end
         rep_pkg::ST_EXEC: begin
            if (stat.is_frame) begin
               state_in = rep_pkg::ST_DIFF;
            end else begin
               new_on_in = stat.rumble;
               state_in  = rep_pkg::ST_DONE;
            end
         end
         rep_pkg::ST_DIFF: state_in = rep_pkg::ST_CHECK;
         rep_pkg::ST_CHECK: begin
            if (stat.env_done) begin
               new_on_in = 1'b0;
               state_in  = rep_pkg::ST_DONE;
            end else if (!stat.num_pos) begin
               new_on_in = 1'b1;
               state_in  = rep_pkg::ST_DONE;
            end else begin
               cnt_in   = 5'd3;
               state_in = rep_pkg::ST_DIVIDE;
            end
         end
         rep_pkg::ST_DIVIDE: begin
            if (cnt_ff == 5'd0) state_in = rep_pkg::ST_PERIOD;
            else cnt_in = cnt_ff - 5'd1;
         end
         rep_pkg::ST_PERIOD: begin
            if (stat.q_zero) begin
               new_on_in = 1'b1;
               state_in  = rep_pkg::ST_DONE;
            end else begin
               cnt_in   = 5'd31;
               state_in = rep_pkg::ST_MODULO;
            end
         end
         rep_pkg::ST_MODULO: begin
            if (cnt_ff == 5'd0) state_in = rep_pkg::ST_MODEND;
            else cnt_in = cnt_ff - 5'd1;
         end
         rep_pkg::ST_MODEND: begin
            new_on_in = stat.mod_zero;
            state_in  = rep_pkg::ST_DONE;
         end
         rep_pkg::ST_DONE: begin
            if (out_free) state_in = rep_pkg::ST_IDLE;
         end
         default: state_in = rep_pkg::ST_IDLE;
      endcase
   end

   // Command outputs
   always_comb begin
      cmd          = '0;
      cmd.bit_idx  = cnt_ff;
      cmd.on_value = new_on_ff;
      busy         = (state_ff != rep_pkg::ST_IDLE);
      case (state_ff)
         rep_pkg::ST_IDLE:   cmd.latch    = req_accept;
         rep_pkg::ST_EXEC:   cmd.exec     = 1'b1;
         rep_pkg::ST_DIFF:   cmd.diff     = 1'b1;
         rep_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
         rep_pkg::ST_PERIOD: cmd.mod_init = !stat.q_zero;
         rep_pkg::ST_MODULO: cmd.mod_step = 1'b1;
         rep_pkg::ST_DONE:   cmd.commit   = out_free;
         default: ;
      endcase
   end

endmodule

>>> sv/rep_dp.sv
`timescale 1ns / 1ps

module rep_dp (
   input  logic                              clock,
   input  logic                              reset,
   input  rep_pkg::rep_cmd_type              cmd,
   input  logic                              motor_present,
   input  logic [1:0]                        req_command,
   input  logic [rep_pkg::LVL_W-1:0]         req_start_level,
   input  logic [rep_pkg::LVL_W-1:0]         req_end_level,
   input  logic [rep_pkg::DUR_W-1:0]         req_request_duration,
   input  logic [rep_pkg::DUR_W-1:0]         req_time_step,
   input  logic                              req_suppressed,
   output rep_pkg::rep_stat_type             stat,
   output logic [1:0]                        rsp_motor_action,
   output logic                              rsp_motor_on
);

   // Latched request
   logic [1:0]                cmd_ff;
   logic [rep_pkg::LVL_W-1:0] start_ff, end_ff;
   logic [rep_pkg::DUR_W-1:0] dur_ff, step_ff;
   logic                      supp_ff;

   // Envelope state
   logic [rep_pkg::DUR_W-1:0] env_dur_ff, env_elapsed_ff;
   logic [rep_pkg::LVL_W-1:0] env_start_ff, env_end_ff;
   logic [rep_pkg::FC_W-1:0]  frame_ff;
   logic                      rumble_ff;
   logic [1:0]                action_ff;

   // Arithmetic registers
   logic signed [rep_pkg::PROD_W-1:0] prod_a_ff, prod_b_ff;
   logic [rep_pkg::REM_W-1:0]         rem_ff;
   logic [rep_pkg::Q_W-1:0]           q_ff;
   logic [rep_pkg::Q_W-1:0]           period_ff;
   logic [rep_pkg::Q_W-1:0]           mrem_ff;
   logic                              num_pos_ff;

   logic signed [rep_pkg::LVL_W:0]    lvl_gap, lvl_slope;
   logic signed [rep_pkg::DUR_W:0]    dur_s, ela_s;
   logic signed [rep_pkg::PROD_W-1:0] prod_a, prod_b;
   logic signed [rep_pkg::NUM_W-1:0]  num;
   logic [rep_pkg::DUR_W:0]           ela_sum;
   logic [rep_pkg::DUR_W-1:0]         remaining;
   logic [rep_pkg::LVL_W:0]           new_sum, cur_sum;
   logic                              take_req;
   logic [rep_pkg::REM_W-1:0]         div_sub;
   logic [rep_pkg::Q_W:0]             mod_trial;

   assign lvl_gap   = signed'(rep_pkg::FULL_SCALE) - signed'({1'b0, env_start_ff});
   assign lvl_slope = signed'({1'b0, env_end_ff}) - signed'({1'b0, env_start_ff});
   assign dur_s     = signed'({1'b0, env_dur_ff});
   assign ela_s     = signed'({1'b0, env_elapsed_ff});
   assign prod_a    = lvl_gap * dur_s;
   assign prod_b    = lvl_slope * ela_s;
   assign num       = {prod_a_ff[rep_pkg::PROD_W-1], prod_a_ff}
                    - {prod_b_ff[rep_pkg::PROD_W-1], prod_b_ff};

   assign ela_sum   = {1'b0, env_elapsed_ff} + {1'b0, step_ff};
   assign remaining = (env_dur_ff >= env_elapsed_ff) ? env_dur_ff - env_elapsed_ff : '0;
   assign new_sum   = {1'b0, start_ff} + {1'b0, end_ff};
   assign cur_sum   = {1'b0, env_start_ff} + {1'b0, env_end_ff};
   assign take_req  = motor_present && (dur_ff != '0) && !supp_ff
                    && ((remaining <= rep_pkg::NEAR_END_LIMIT) || (new_sum >= cur_sum));

   assign div_sub   = {{(rep_pkg::REM_W-rep_pkg::DUR_W){1'b0}}, env_dur_ff} << cmd.bit_idx[1:0];
   assign mod_trial = {mrem_ff, frame_ff[cmd.bit_idx]};

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         cmd_ff   <= req_command;
         start_ff <= req_start_level;
         end_ff   <= req_end_level;
         dur_ff   <= req_request_duration;
         step_ff  <= req_time_step;
         supp_ff  <= req_suppressed;
      end
      if (cmd.exec) begin
         prod_a_ff <= prod_a;
         prod_b_ff <= prod_b;
      end
      if (cmd.diff) begin
         num_pos_ff <= !num[rep_pkg::NUM_W-1] && (num != '0);
         rem_ff     <= num[rep_pkg::REM_W+15:16];
         q_ff       <= '0;
      end
      if (cmd.div_step && (rem_ff >= div_sub)) begin
         rem_ff                  <= rem_ff - div_sub;
         q_ff[cmd.bit_idx[1:0]]  <= 1'b1;
      end
      if (cmd.mod_init) begin
         period_ff <= q_ff + 4'd1;
         mrem_ff   <= '0;
      end
      if (cmd.mod_step) begin
         if (mod_trial >= {1'b0, period_ff}) mrem_ff <= 4'(mod_trial - {1'b0, period_ff});
         else mrem_ff <= mod_trial[rep_pkg::Q_W-1:0];
      end
      if (cmd.commit) begin
         if (cmd.on_value == rumble_ff) action_ff <= rep_pkg::ACT_NONE;
         else if (cmd.on_value) action_ff <= rep_pkg::ACT_START;
         else action_ff <= rep_pkg::ACT_STOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_dur_ff     <= '0;
         env_elapsed_ff <= '0;
         env_start_ff   <= '0;
         env_end_ff     <= '0;
         frame_ff       <= '0;
         rumble_ff      <= 1'b0;
      end else begin
         if (cmd.exec) begin
            case (cmd_ff)
               rep_pkg::CMD_FRAME: frame_ff <= frame_ff + 32'd1;
               rep_pkg::CMD_TIME: begin
                  if (motor_present) begin
                     if (ela_sum < {1'b0, env_dur_ff})
                        env_elapsed_ff <= ela_sum[rep_pkg::DUR_W-1:0];
                     else
                        env_elapsed_ff <= env_dur_ff;
                  end
               end
               rep_pkg::CMD_REQUEST: begin
                  if (take_req) begin
                     env_dur_ff     <= dur_ff;
                     env_elapsed_ff <= '0;
                     env_start_ff   <= start_ff;
                     env_end_ff     <= end_ff;
                  end
               end
               default: ;
            endcase
         end
         if (cmd.commit) rumble_ff <= cmd.on_value;
      end
   end

   always_comb begin
      stat.is_frame = (cmd_ff == rep_pkg::CMD_FRAME);
      stat.rumble   = rumble_ff;
      stat.env_done = (env_elapsed_ff == env_dur_ff);
      stat.num_pos  = num_pos_ff;
      stat.q_zero   = (q_ff == '0);
      stat.mod_zero = (mrem_ff == '0);
   end

   assign rsp_motor_action = action_ff;
   assign rsp_motor_on     = rumble_ff;

endmodule

>>> sv/rumble_envelope_pulser.sv
`timescale 1ns / 1ps

// Rumble envelope pulser: drives a haptic motor from a linear level envelope.
// Request channel (req_*): one request per handshake, accepted at a clock edge
// with req_valid high and req_stall low. req_command selects a frame tick, a
// time advance or a new rumble envelope. Every request gives exactly one
// response on rsp_* (rsp_valid / rsp_stall): a start/stop action and the
// motor on state after that request.
// Config port (csr_*): writes motor_present; always ready, write only while
// no request is in flight. Without a motor, envelopes and time advances drop.
// Time advance and envelope requests are committed straight after the execute
// state. A frame tick multiplies, subtracts, divides the level to a pulse
// period with a 4-step restoring divider and then reduces the 32-bit frame
// count modulo that period one bit per cycle, stopping early when the motor
// is plainly on or off. One request is in work at a time, so the next one is
// taken only after the last has been committed to the output register.
// The response sits in an output register; the next request is taken while it
// waits, but the block holds its result when the receiver stalls.
// Reset (synchronous) clears the envelope, frame count, motor state and config.

module rumble_envelope_pulser (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [1:0]                        req_command,
   input  logic [rep_pkg::LVL_W-1:0]         req_start_level,
   input  logic [rep_pkg::LVL_W-1:0]         req_end_level,
   input  logic [rep_pkg::DUR_W-1:0]         req_request_duration,
   input  logic [rep_pkg::DUR_W-1:0]         req_time_step,
   input  logic                              req_suppressed,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [1:0]                        rsp_motor_action,
   output logic                              rsp_motor_on,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_motor_present
);

   logic                  motor_present_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  busy;
   logic                  req_accept;
   logic                  out_free;
   rep_pkg::rep_cmd_type  cmd;
   rep_pkg::rep_stat_type stat;

   // Config register: single bit, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) motor_present_ff <= 1'b0;
      else if (csr_valid && csr_ready) motor_present_ff <= csr_motor_present;
   end

   // Take a request only while the controller is idle
   assign req_stall  = busy;
   assign req_accept = req_valid && !req_stall;

   // Output slot is free when empty or being drained this cycle
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = cmd.commit || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else rsp_valid_ff <= rsp_valid_in;
   end

   assign rsp_valid = rsp_valid_ff;

   rep_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .out_free   (out_free),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd)
   );

   rep_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .motor_present        (motor_present_ff),
      .req_command          (req_command),
      .req_start_level      (req_start_level),
      .req_end_level        (req_end_level),
      .req_request_duration (req_request_duration),
      .req_time_step        (req_time_step),
      .req_suppressed       (req_suppressed),
      .stat                 (stat),
      .rsp_motor_action     (rsp_motor_action),
      .rsp_motor_on         (rsp_motor_on)
   );

   // Block goes busy right after taking a request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (!reset && req_accept) |=> req_stall)
      else $error("request accepted but block not busy");

   // A commit always presents a response next cycle
   a_commit_valid: assert property (@(posedge clock) disable iff (reset)
      (!reset && cmd.commit) |=> rsp_valid)
      else $error("commit without response valid");

   // Motor state moves only on a commit
   a_on_stable: assert property (@(posedge clock) disable iff (reset)
      (!reset && !cmd.commit) |=> $stable(rsp_motor_on))
      else $error("motor state changed without commit");

   // Action agrees with the reported state
   a_action_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_motor_action == rep_pkg::ACT_START)) |-> rsp_motor_on)
      else $error("start action with motor off");

   a_stop_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_motor_action == rep_pkg::ACT_STOP)) |-> !rsp_motor_on)
      else $error("stop action with motor on");

endmodule
